>>> design/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes of the priority task scheduler: datapath operations,
// result status codes, command modes and the controller/datapath link.
// ----------------------------------------------------------------------------
package ptts_pkg;

	// command modes
	localparam logic [2:0] MODE_ADD     = 3'd0;
	localparam logic [2:0] MODE_QTASK   = 3'd1;
	localparam logic [2:0] MODE_QTHREAD = 3'd2;
	localparam logic [2:0] MODE_RUN     = 3'd3;
	localparam logic [2:0] MODE_FINISH  = 3'd4;

	// result status codes
	localparam logic [3:0] ST_CREATED  = 4'd0;
	localparam logic [3:0] ST_RUNNING  = 4'd1;
	localparam logic [3:0] ST_WAITING  = 4'd2;
	localparam logic [3:0] ST_FINISHED = 4'd3;
	localparam logic [3:0] ST_NOTFOUND = 4'd4;
	localparam logic [3:0] ST_IDLE     = 4'd5;
	localparam logic [3:0] ST_BUSY     = 4'd6;
	localparam logic [3:0] ST_NOREPORT = 4'd7;
	localparam logic [3:0] ST_REJECTED = 4'd8;
	localparam logic [3:0] ST_TIME     = 4'd9;

	// configuration register indexes
	localparam logic REG_QUANTUM = 1'b0;
	localparam logic REG_THREADS = 1'b1;

	// results per add command never exceed this
	localparam int BATCH_CAP = 16;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SC_INIT,
		OP_IDX_INC,
		OP_ADD_WR,
		OP_QT_RD,
		OP_OWN_RD,
		OP_OWN_TM_RD,
		OP_SC_RD,
		OP_SC_CMP,
		OP_DEC_EV,
		OP_ASSIGN_RD,
		OP_ASSIGN,
		OP_RELEASE,
		OP_CH_INIT_Q,
		OP_CH_INIT_R,
		OP_RUN_FULL,
		OP_RUN_FIN,
		OP_FIN_ACC,
		OP_FIN_REP,
		OP_EMIT
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t        op;
		logic [3:0] code;
		logic       last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic       cnt_zero;
		logic       cnt_one;
		logic       used;
		logic       flag_wait;
		logic       flag_run;
		logic       flag_fin;
		logic       idx_last;
		logic       qid_ok;
		logic       q_run;
		logic       q_wait;
		logic       q_rec;
		logic       in_pool;
		logic       thr_busy;
		logic       loop;
		logic       rt_ge_d;
		logic       any_task;
		logic       disp_ok;
		logic       fin_any;
		logic       out_busy;
	} stat_t;

endpackage

>>> design/ptts_dp.sv
// ----------------------------------------------------------------------------
// ptts_dp
// Scheduler datapath: task table, finish-time store, idle thread stack,
// thread owner table, scan index, candidate registers and result register.
// ----------------------------------------------------------------------------
module ptts_dp import ptts_pkg::*; #(
	parameter int MAX_TASKS   = 64,
	parameter int MAX_THREADS = 64,
	parameter int MAX_BATCH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [2:0]  in_mode,
	input  logic [4:0]  in_task_count,
	input  logic [15:0] in_exec_time,
	input  logic [7:0]  in_priority_req,
	input  logic [6:0]  in_query_id,
	input  logic [15:0] in_run_time,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  out_status,
	output logic [6:0]  out_task_id,
	output logic [5:0]  out_thread_id,
	output logic [15:0] out_time_value,
	output logic [23:0] out_elapsed,
	output logic        out_last
);

	localparam int IW  = $clog2(MAX_TASKS);
	localparam int TW  = $clog2(MAX_THREADS);
	localparam int PW  = TW + 1;
	localparam int LIM = (MAX_BATCH < BATCH_CAP) ? MAX_BATCH : BATCH_CAP;
	localparam int POOL_RST = (MAX_THREADS < 4) ? MAX_THREADS : 4;

	typedef struct packed {
		logic [7:0]    prio;
		logic [15:0]   exec;
		logic [15:0]   remain;
		logic [TW-1:0] thr;
	} ent_t;

	// saturating add into the 24-bit total
	function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [16:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {8'd0, b};
		return s[24] ? 24'hFFFFFF : s[23:0];
	endfunction

	// pool size from a thread_pairs value
	function automatic logic [PW-1:0] pool_of(input logic [5:0] v);
		logic [6:0] n;
		n = {v, 1'b0};
		if (n < 7'd2) n = 7'd2;
		if (32'(n) > MAX_THREADS) n = 7'(MAX_THREADS);
		return PW'(n);
	endfunction

	// command item
	logic [2:0]  mode_q;
	logic [4:0]  cnt_q;
	logic [15:0] exec_q;
	logic [7:0]  prio_q;
	logic [6:0]  qid_q;
	logic [15:0] rt_q;
	logic        loop_q;

	// configuration and shared state
	logic [15:0]            quantum_q;
	logic [PW-1:0]          pool_q;
	logic [PW-1:0]          top_q;
	logic [MAX_TASKS-1:0]   wait_q;
	logic [MAX_TASKS-1:0]   run_q;
	logic [MAX_TASKS-1:0]   fin_q;
	logic [MAX_TASKS-1:0]   rec_q;
	logic [MAX_THREADS-1:0] busy_q;
	logic [MAX_THREADS-1:0] svld_q;
	logic [23:0]            total_q;

	// memories
	ent_t          tm_mem [MAX_TASKS];
	ent_t          tm_rd_q;
	logic [15:0]   rec_mem [MAX_TASKS];
	logic [15:0]   rec_rd_q;
	logic [TW-1:0] stk_mem [MAX_THREADS];
	logic [TW-1:0] stk_rd_q;
	logic          stk_rdv_q;
	logic [IW-1:0] own_mem [MAX_THREADS];
	logic [IW-1:0] own_rd_q;

	// scan and chunk state
	logic [IW-1:0] idx_q;
	logic [IW-1:0] cand_id_q;
	logic          cand_v_q;
	ent_t          cand_q;
	logic [15:0]   t_q;
	logic [15:0]   cbest_q;
	logic [15:0]   bmax_q;
	logic [23:0]   rep_q;

	// result register
	logic        out_valid_q;
	logic [3:0]  out_status_q;
	logic [6:0]  out_task_q;
	logic [5:0]  out_thread_q;
	logic [15:0] out_time_q;
	logic [23:0] out_elapsed_q;
	logic        out_last_q;

	logic [15:0]   eff_q;
	logic [IW-1:0] qidx;
	logic [TW-1:0] tidx;
	logic [TW-1:0] thr_pop;
	logic [TW-1:0] top_m1;
	logic [TW-1:0] top_ix;
	logic          better;
	logic          done_now;
	logic [16:0]   run_v;
	logic          tm_we;
	logic [IW-1:0] tm_wa;
	ent_t          tm_wd;
	logic          tm_re;
	logic [IW-1:0] tm_ra;
	logic [3:0]    e_status;
	logic [6:0]    e_task;
	logic [5:0]    e_thread;
	logic [15:0]   e_time;
	logic [23:0]   e_elapsed;

	// derived values
	assign eff_q    = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
	assign qidx     = IW'(32'(qid_q) - 1);
	assign tidx     = TW'(qid_q);
	assign top_m1   = TW'(top_q - PW'(1));
	assign top_ix   = TW'(top_q);
	assign thr_pop  = stk_rdv_q ? stk_rd_q : TW'(pool_q - top_q);
	assign done_now = tm_rd_q.remain <= t_q;
	assign run_v    = {1'b0, bmax_q} + {1'b0, cbest_q};
	assign better   = !cand_v_q || (tm_rd_q.prio > cand_q.prio) ||
		((tm_rd_q.prio == cand_q.prio) && (tm_rd_q.exec < cand_q.exec));

	// status to the controller
	always_comb begin
		stat.mode      = mode_q;
		stat.cnt_zero  = cnt_q == 5'd0;
		stat.cnt_one   = cnt_q == 5'd1;
		stat.used      = wait_q[idx_q] | run_q[idx_q] | fin_q[idx_q];
		stat.flag_wait = wait_q[idx_q];
		stat.flag_run  = run_q[idx_q];
		stat.flag_fin  = fin_q[idx_q];
		stat.idx_last  = idx_q == IW'(MAX_TASKS - 1);
		stat.qid_ok    = (qid_q != 7'd0) && (32'(qid_q) <= MAX_TASKS);
		stat.q_run     = run_q[qidx];
		stat.q_wait    = wait_q[qidx];
		stat.q_rec     = rec_q[qidx];
		stat.in_pool   = 32'(qid_q) < 32'(pool_q);
		stat.thr_busy  = busy_q[tidx];
		stat.loop      = loop_q;
		stat.rt_ge_d   = rt_q >= eff_q;
		stat.any_task  = |(wait_q | run_q);
		stat.disp_ok   = (|wait_q) && (top_q != '0);
		stat.fin_any   = |fin_q;
		stat.out_busy  = out_valid_q;
	end

	// task table port selection
	always_comb begin
		tm_we = 1'b0;
		tm_wa = idx_q;
		tm_wd = tm_rd_q;
		tm_re = 1'b0;
		tm_ra = idx_q;
		unique case (cmd.op)
			OP_ADD_WR: begin
				tm_we = 1'b1;
				tm_wd = '{prio: prio_q, exec: exec_q, remain: exec_q, thr: '0};
			end
			OP_ASSIGN: begin
				tm_we     = 1'b1;
				tm_wa     = cand_id_q;
				tm_wd     = cand_q;
				tm_wd.thr = thr_pop;
			end
			OP_DEC_EV: begin
				tm_we        = !done_now;
				tm_wd.remain = tm_rd_q.remain - t_q;
			end
			OP_SC_RD:     tm_re = 1'b1;
			OP_QT_RD: begin
				tm_re = 1'b1;
				tm_ra = qidx;
			end
			OP_OWN_TM_RD: begin
				tm_re = 1'b1;
				tm_ra = own_rd_q;
			end
			default: ;
		endcase
	end

	// result fields by status code
	always_comb begin
		e_status  = cmd.code;
		e_task    = 7'd0;
		e_thread  = 6'd0;
		e_time    = 16'd0;
		e_elapsed = 24'd0;
		case (cmd.code)
			ST_CREATED:  e_task = 7'(32'(idx_q) + 1);
			ST_RUNNING: begin
				e_task   = qid_q;
				e_thread = 6'(tm_rd_q.thr);
				e_time   = tm_rd_q.remain;
			end
			ST_WAITING: begin
				e_task = qid_q;
				e_time = tm_rd_q.remain;
			end
			ST_FINISHED: begin
				e_task = qid_q;
				e_time = rec_rd_q;
			end
			ST_NOTFOUND: e_task = qid_q;
			ST_IDLE:     e_thread = qid_q[5:0];
			ST_BUSY: begin
				e_task   = 7'(32'(own_rd_q) + 1);
				e_thread = qid_q[5:0];
				e_time   = tm_rd_q.remain;
			end
			ST_TIME:     e_elapsed = rep_q;
			default: ;
		endcase
	end

	// memories and payload registers
	always_ff @(posedge clk) begin
		if (tm_we) tm_mem[tm_wa] <= tm_wd;
		if (tm_re) tm_rd_q <= tm_mem[tm_ra];
		if (cmd.op == OP_RELEASE && !rec_q[cand_id_q]) rec_mem[cand_id_q] <= cand_q.exec;
		if (cmd.op == OP_QT_RD) rec_rd_q <= rec_mem[qidx];
		if (cmd.op == OP_RELEASE) stk_mem[top_ix] <= cand_q.thr;
		if (cmd.op == OP_ASSIGN_RD) begin
			stk_rd_q  <= stk_mem[top_m1];
			stk_rdv_q <= svld_q[top_m1];
		end
		if (cmd.op == OP_ASSIGN) own_mem[thr_pop] <= cand_id_q;
		if (cmd.op == OP_OWN_RD) own_rd_q <= own_mem[tidx];

		case (cmd.op)
			OP_LOAD: begin
				mode_q <= in_mode;
				exec_q <= in_exec_time;
				prio_q <= in_priority_req;
				qid_q  <= in_query_id;
				rt_q   <= in_run_time;
				loop_q <= in_run_time > eff_q;
				bmax_q <= 16'd0;
			end
			OP_SC_INIT: begin
				idx_q    <= '0;
				cand_v_q <= 1'b0;
			end
			OP_IDX_INC, OP_DEC_EV: idx_q <= idx_q + IW'(1);
			OP_SC_CMP: begin
				idx_q <= idx_q + IW'(1);
				if (better) begin
					cand_v_q  <= 1'b1;
					cand_id_q <= idx_q;
					cand_q    <= tm_rd_q;
				end
			end
			OP_CH_INIT_Q: begin
				t_q     <= eff_q;
				cbest_q <= 16'd0;
			end
			OP_CH_INIT_R: begin
				t_q     <= rt_q;
				cbest_q <= 16'd0;
			end
			OP_RELEASE: if (cand_q.exec > cbest_q) cbest_q <= cand_q.exec;
			OP_RUN_FULL: begin
				if (cbest_q > bmax_q) bmax_q <= cbest_q;
				rt_q <= rt_q - eff_q;
			end
			OP_RUN_FIN: rep_q <= 24'(run_v);
			OP_FIN_REP: rep_q <= total_q;
			OP_EMIT: begin
				out_status_q  <= e_status;
				out_task_q    <= e_task;
				out_thread_q  <= e_thread;
				out_time_q    <= e_time;
				out_elapsed_q <= e_elapsed;
				out_last_q    <= cmd.last;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= 16'd100;
			pool_q      <= PW'(POOL_RST);
			top_q       <= PW'(POOL_RST);
			wait_q      <= '0;
			run_q       <= '0;
			fin_q       <= '0;
			rec_q       <= '0;
			busy_q      <= '0;
			svld_q      <= '0;
			total_q     <= 24'd0;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				if (cfg_index == REG_QUANTUM) begin
					quantum_q <= cfg_data;
				end else if (!(|run_q)) begin
					pool_q <= pool_of(cfg_data[5:0]);
					top_q  <= pool_of(cfg_data[5:0]);
					svld_q <= '0;
				end
			end
			// output beat taken
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: cnt_q <= (32'(in_task_count) > LIM) ? 5'(LIM) : in_task_count;
				OP_ADD_WR: begin
					wait_q[idx_q] <= 1'b1;
					cnt_q         <= cnt_q - 5'd1;
				end
				OP_DEC_EV: if (done_now) begin
					run_q[idx_q] <= 1'b0;
					fin_q[idx_q] <= 1'b1;
				end
				OP_ASSIGN: begin
					wait_q[cand_id_q] <= 1'b0;
					run_q[cand_id_q]  <= 1'b1;
					busy_q[thr_pop]   <= 1'b1;
					top_q             <= top_q - PW'(1);
				end
				OP_RELEASE: begin
					svld_q[top_ix]     <= 1'b1;
					top_q              <= top_q + PW'(1);
					busy_q[cand_q.thr] <= 1'b0;
					fin_q[cand_id_q]   <= 1'b0;
					rec_q[cand_id_q]   <= 1'b1;
				end
				OP_RUN_FIN: total_q <= sat_add(total_q, run_v);
				OP_FIN_ACC: total_q <= sat_add(total_q, {1'b0, cbest_q});
				OP_EMIT:    out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_task_id    = out_task_q;
	assign out_thread_id  = out_thread_q;
	assign out_time_value = out_time_q;
	assign out_elapsed    = out_elapsed_q;
	assign out_last       = out_last_q;

endmodule

>>> design/ptts_ctrl.sv
// ----------------------------------------------------------------------------
// ptts_ctrl
// Scheduler controller: sequences command decode, table scans, dispatch,
// finish selection, time chunks and result emission.
// ----------------------------------------------------------------------------
module ptts_ctrl import ptts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [22:0] {
		S_IDLE     = 23'd1 << 0,
		S_DEC      = 23'd1 << 1,
		S_EMIT     = 23'd1 << 2,
		S_ADD_SCAN = 23'd1 << 3,
		S_ADD_WR   = 23'd1 << 4,
		S_QT_EM    = 23'd1 << 5,
		S_QH_TM    = 23'd1 << 6,
		S_RUN_CHK  = 23'd1 << 7,
		S_RUN_FULL = 23'd1 << 8,
		S_RUN_END  = 23'd1 << 9,
		S_FIN_CHK  = 23'd1 << 10,
		S_FIN_ACC  = 23'd1 << 11,
		S_D_CHK    = 23'd1 << 12,
		S_D_SCAN   = 23'd1 << 13,
		S_D_CMP    = 23'd1 << 14,
		S_D_ASRD   = 23'd1 << 15,
		S_D_ASN    = 23'd1 << 16,
		S_R_SCAN   = 23'd1 << 17,
		S_R_EV     = 23'd1 << 18,
		S_S_CHK    = 23'd1 << 19,
		S_S_SCAN   = 23'd1 << 20,
		S_S_CMP    = 23'd1 << 21,
		S_S_REL    = 23'd1 << 22
	} state_t;

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	state_t     cret_q, cret_d;
	logic [3:0] code_q, code_d;
	logic       last_q, last_d;
	logic       post_q, post_d;

	assign in_ready = state_q == S_IDLE;

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cret_d   = cret_q;
		code_d   = code_q;
		last_d   = last_q;
		post_d   = post_q;
		cmd.op   = OP_NONE;
		cmd.code = code_q;
		cmd.last = last_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op  = OP_LOAD;
				state_d = S_DEC;
			end
			S_DEC: begin
				state_d = S_EMIT;
				last_d  = 1'b1;
				ret_d   = S_IDLE;
				code_d  = ST_NOREPORT;
				case (stat.mode)
					MODE_ADD: if (!stat.cnt_zero) begin
						cmd.op  = OP_SC_INIT;
						state_d = S_ADD_SCAN;
					end
					MODE_QTASK: if (stat.qid_ok) begin
						cmd.op  = OP_QT_RD;
						state_d = S_QT_EM;
					end else begin
						code_d = ST_NOTFOUND;
					end
					MODE_QTHREAD: if (stat.in_pool) begin
						if (stat.thr_busy) begin
							cmd.op  = OP_OWN_RD;
							state_d = S_QH_TM;
						end else begin
							code_d = ST_IDLE;
						end
					end
					MODE_RUN:    state_d = S_RUN_CHK;
					MODE_FINISH: state_d = S_FIN_CHK;
					default: ;
				endcase
			end
			S_QT_EM: begin
				state_d = S_EMIT;
				if (stat.q_run)       code_d = ST_RUNNING;
				else if (stat.q_wait) code_d = ST_WAITING;
				else if (stat.q_rec)  code_d = ST_FINISHED;
				else                  code_d = ST_NOTFOUND;
			end
			S_QH_TM: begin
				cmd.op  = OP_OWN_TM_RD;
				code_d  = ST_BUSY;
				state_d = S_EMIT;
			end
			// lowest free id
			S_ADD_SCAN: begin
				if (!stat.used) begin
					state_d = S_ADD_WR;
				end else if (stat.idx_last) begin
					code_d  = ST_REJECTED;
					last_d  = 1'b1;
					ret_d   = S_IDLE;
					state_d = S_EMIT;
				end else begin
					cmd.op = OP_IDX_INC;
				end
			end
			S_ADD_WR: begin
				cmd.op  = OP_ADD_WR;
				code_d  = ST_CREATED;
				last_d  = stat.cnt_one;
				ret_d   = stat.cnt_one ? S_IDLE : S_ADD_SCAN;
				state_d = S_EMIT;
			end
			// run command chunks
			S_RUN_CHK: begin
				post_d  = 1'b0;
				state_d = S_D_CHK;
				if (stat.loop && stat.rt_ge_d) begin
					cmd.op = OP_CH_INIT_Q;
					cret_d = S_RUN_FULL;
				end else begin
					cmd.op = OP_CH_INIT_R;
					cret_d = S_RUN_END;
				end
			end
			S_RUN_FULL: begin
				cmd.op  = OP_RUN_FULL;
				state_d = S_RUN_CHK;
			end
			S_RUN_END: begin
				cmd.op  = OP_RUN_FIN;
				code_d  = ST_TIME;
				last_d  = 1'b1;
				ret_d   = S_IDLE;
				state_d = S_EMIT;
			end
			// finish command chunks
			S_FIN_CHK: begin
				if (stat.any_task) begin
					cmd.op  = OP_CH_INIT_Q;
					cret_d  = S_FIN_ACC;
					post_d  = 1'b0;
					state_d = S_D_CHK;
				end else begin
					cmd.op  = OP_FIN_REP;
					code_d  = ST_TIME;
					last_d  = 1'b1;
					ret_d   = S_IDLE;
					state_d = S_EMIT;
				end
			end
			S_FIN_ACC: begin
				cmd.op  = OP_FIN_ACC;
				state_d = S_FIN_CHK;
			end
			// dispatch: best waiting task onto top idle thread
			S_D_CHK: begin
				if (stat.disp_ok) begin
					cmd.op  = OP_SC_INIT;
					state_d = S_D_SCAN;
				end else if (post_q) begin
					state_d = cret_q;
				end else begin
					cmd.op  = OP_SC_INIT;
					state_d = S_R_SCAN;
				end
			end
			S_D_SCAN: begin
				if (stat.flag_wait) begin
					cmd.op  = OP_SC_RD;
					state_d = S_D_CMP;
				end else if (stat.idx_last) begin
					state_d = S_D_ASRD;
				end else begin
					cmd.op = OP_IDX_INC;
				end
			end
			S_D_CMP: begin
				cmd.op  = OP_SC_CMP;
				state_d = stat.idx_last ? S_D_ASRD : S_D_SCAN;
			end
			S_D_ASRD: begin
				cmd.op  = OP_ASSIGN_RD;
				state_d = S_D_ASN;
			end
			S_D_ASN: begin
				cmd.op  = OP_ASSIGN;
				state_d = S_D_CHK;
			end
			// age running tasks by the chunk time
			S_R_SCAN: begin
				if (stat.flag_run) begin
					cmd.op  = OP_SC_RD;
					state_d = S_R_EV;
				end else if (stat.idx_last) begin
					state_d = S_S_CHK;
				end else begin
					cmd.op = OP_IDX_INC;
				end
			end
			S_R_EV: begin
				cmd.op  = OP_DEC_EV;
				state_d = stat.idx_last ? S_S_CHK : S_R_SCAN;
			end
			// release finished tasks by priority, then shorter execution, then lower id
			S_S_CHK: begin
				if (stat.fin_any) begin
					cmd.op  = OP_SC_INIT;
					state_d = S_S_SCAN;
				end else begin
					post_d  = 1'b1;
					state_d = S_D_CHK;
				end
			end
			S_S_SCAN: begin
				if (stat.flag_fin) begin
					cmd.op  = OP_SC_RD;
					state_d = S_S_CMP;
				end else if (stat.idx_last) begin
					state_d = S_S_REL;
				end else begin
					cmd.op = OP_IDX_INC;
				end
			end
			S_S_CMP: begin
				cmd.op  = OP_SC_CMP;
				state_d = stat.idx_last ? S_S_REL : S_S_SCAN;
			end
			S_S_REL: begin
				cmd.op  = OP_RELEASE;
				state_d = S_S_CHK;
			end
			// result beat into the output register
			S_EMIT: if (!stat.out_busy) begin
				cmd.op  = OP_EMIT;
				state_d = ret_q;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			cret_q  <= S_IDLE;
			code_q  <= ST_NOREPORT;
			last_q  <= 1'b0;
			post_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			cret_q  <= cret_d;
			code_q  <= code_d;
			last_q  <= last_d;
			post_q  <= post_d;
		end
	end

endmodule

>>> design/priority_task_thread_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_task_thread_scheduler_unit
// Priority task scheduler with a worker thread pool, stream command in,
// stream results out.
// ----------------------------------------------------------------------------
// One command is worked on at a time; s_axis_tready is high only between
// commands, while the last result may still wait in the output register.
// Each added task scans the ID flags one per cycle from the last found ID.
// A time chunk is sequenced over the task table entry by entry, a live
// entry being read before it is used: one full scan per dispatched task, one
// scan to age running tasks and one scan per finished task; run and finish
// commands repeat this for each quantum chunk. The single-port task table
// sets this sequencing. No clearing pass is needed after reset.
module priority_task_thread_scheduler_unit import ptts_pkg::*; #(
	parameter int MAX_TASKS   = 64,
	parameter int MAX_THREADS = 64,
	parameter int MAX_BATCH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[2:0], task_count[7:3], exec_time[23:8], priority_req[31:24],
	// query_id[38:32], run_time[54:39], zero pad[55]
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[3:0], task_id[10:4], thread_id[16:11], time_value[32:17],
	// elapsed[56:33], zero pad[63:57]
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	cmd_t        cmd;
	stat_t       stat;
	logic [3:0]  o_status;
	logic [6:0]  o_task;
	logic [5:0]  o_thread;
	logic [15:0] o_time;
	logic [23:0] o_elapsed;

	ptts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ptts_dp #(
		.MAX_TASKS   (MAX_TASKS),
		.MAX_THREADS (MAX_THREADS),
		.MAX_BATCH   (MAX_BATCH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_mode         (s_axis_tdata[2:0]),
		.in_task_count   (s_axis_tdata[7:3]),
		.in_exec_time    (s_axis_tdata[23:8]),
		.in_priority_req (s_axis_tdata[31:24]),
		.in_query_id     (s_axis_tdata[38:32]),
		.in_run_time     (s_axis_tdata[54:39]),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_status      (o_status),
		.out_task_id     (o_task),
		.out_thread_id   (o_thread),
		.out_time_value  (o_time),
		.out_elapsed     (o_elapsed),
		.out_last        (m_axis_tlast)
	);

	// result beat packing
	assign m_axis_tdata = {7'd0, o_elapsed, o_time, o_thread, o_task, o_status};

`ifndef SYNTHESIS
	// a command beat starts work, so no second beat is taken right after
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("command accepted while busy");

	// a result is loaded only into an empty output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> !m_axis_tvalid)
		else $error("pending result overwritten");
`endif

endmodule

>>> dv/ptts_checker.sv
// ----------------------------------------------------------------------------
// ptts_checker
// Watches the command, result and register channels of the scheduler, keeps
// its own model of the task lists and thread pool, and compares every result
// beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module ptts_checker import ptts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          n_errors,
	output int          n_pending,
	output int          n_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NTASK = 64;
	localparam int NTHR  = 64;
	localparam int NBATCH = 16;

	typedef struct packed {
		logic [3:0]  status;
		logic [6:0]  task_id;
		logic [5:0]  thread_id;
		logic [15:0] time_value;
		logic [23:0] elapsed;
		logic        last;
	} sched_result_t;

	typedef struct {
		int unsigned id;
		int unsigned prio;
		int unsigned exec;
		int unsigned remain;
		int unsigned thr;
	} task_rec_t;

	sched_result_t result_q[$];
	task_rec_t     wait_list[$];
	task_rec_t     run_list[$];
	int unsigned   idle_threads[$];
	bit            id_busy[NTASK];
	bit            done_valid[NTASK];
	int unsigned   done_time[NTASK];
	int unsigned   elapsed_sum;
	int unsigned   quantum;
	int unsigned   pairs;

	function automatic int unsigned pool_threads();
		int unsigned n;
		n = 2 * pairs;
		if (n < 2) n = 2;
		if (n > NTHR) n = NTHR;
		return n;
	endfunction

	function automatic void refill_pool();
		int unsigned n;
		n = pool_threads();
		idle_threads.delete();
		for (int unsigned i = 0; i < n; i++) idle_threads.push_back(n - 1 - i);
	endfunction

	// priority first, then shorter execution, then lower id
	function automatic bit ahead_of(task_rec_t a, task_rec_t b);
		if (a.prio != b.prio) return a.prio > b.prio;
		if (a.exec != b.exec) return a.exec < b.exec;
		return a.id < b.id;
	endfunction

	function automatic void insert_sorted(ref task_rec_t l[$], input task_rec_t e);
		int p;
		p = 0;
		if (l.size() >= NTASK) return;
		while (p < l.size() && !ahead_of(e, l[p])) p++;
		l.insert(p, e);
	endfunction

	// hand idle threads (top of stack first) to the head waiting tasks
	function automatic void dispatch();
		task_rec_t e;
		while (wait_list.size() > 0 && idle_threads.size() > 0) begin
			e = wait_list.pop_front();
			e.thr = idle_threads.pop_back();
			insert_sorted(run_list, e);
		end
	endfunction

	// one time slice; returns the longest execution time finished in it
	function automatic int unsigned run_slice(int unsigned t);
		int unsigned best;
		task_rec_t kept[$];
		task_rec_t e;
		best = 0;
		dispatch();
		foreach (run_list[i]) begin
			e = run_list[i];
			if (e.remain <= t) begin
				if (idle_threads.size() < NTHR) idle_threads.push_back(e.thr);
				if (e.id >= 1 && e.id <= NTASK) begin
					id_busy[e.id - 1] = 1'b0;
					if (!done_valid[e.id - 1]) begin
						done_valid[e.id - 1] = 1'b1;
						done_time[e.id - 1] = e.exec;
					end
				end
				if (e.exec > best) best = e.exec;
			end else begin
				e.remain -= t;
				kept.push_back(e);
			end
		end
		run_list = kept;
		dispatch();
		return best;
	endfunction

	function automatic void add_total(int unsigned v);
		elapsed_sum += v;
		if (elapsed_sum > 24'hFFFFFF) elapsed_sum = 24'hFFFFFF;
	endfunction

	function automatic void post(logic [3:0] st, int unsigned tid, int unsigned thr,
			int unsigned tv, int unsigned el, bit last);
		sched_result_t r;
		r.status = st;
		r.task_id = tid[6:0];
		r.thread_id = thr[5:0];
		r.time_value = tv[15:0];
		r.elapsed = el[23:0];
		r.last = last;
		result_q.push_back(r);
	endfunction

	// expected results of one command beat
	function automatic void predict_command(logic [55:0] d);
		logic [2:0]  mode;
		int unsigned cnt, exec, prio, qid, rt, slice, v, best, id;
		task_rec_t   e;
		bit          found;
		mode = d[2:0];
		cnt  = d[7:3];
		exec = d[23:8];
		prio = d[31:24];
		qid  = d[38:32];
		rt   = d[54:39];
		slice = (quantum != 0) ? quantum : 1;
		case (mode)
			MODE_ADD: begin
				if (cnt == 0) begin
					post(ST_NOREPORT, 0, 0, 0, 0, 1);
				end else begin
					if (cnt > NBATCH) cnt = NBATCH;
					if (cnt > BATCH_CAP) cnt = BATCH_CAP;
					while (cnt > 0) begin
						id = 0;
						while (id < NTASK && id_busy[id]) id++;
						if (id >= NTASK) begin
							post(ST_REJECTED, 0, 0, 0, 0, 0);
							break;
						end
						id_busy[id] = 1'b1;
						e.id = id + 1;
						e.prio = prio;
						e.exec = exec;
						e.remain = exec;
						e.thr = 0;
						insert_sorted(wait_list, e);
						post(ST_CREATED, e.id, 0, 0, 0, 0);
						cnt--;
					end
					result_q[$].last = 1'b1;
				end
			end
			MODE_QTASK: begin
				found = 1'b0;
				foreach (run_list[i])
					if (!found && run_list[i].id == qid) begin
						post(ST_RUNNING, qid, run_list[i].thr, run_list[i].remain, 0, 1);
						found = 1'b1;
					end
				foreach (wait_list[i])
					if (!found && wait_list[i].id == qid) begin
						post(ST_WAITING, qid, 0, wait_list[i].remain, 0, 1);
						found = 1'b1;
					end
				if (!found) begin
					if (qid >= 1 && qid <= NTASK && done_valid[qid - 1])
						post(ST_FINISHED, qid, 0, done_time[qid - 1], 0, 1);
					else
						post(ST_NOTFOUND, qid, 0, 0, 0, 1);
				end
			end
			MODE_QTHREAD: begin
				found = 1'b0;
				if (qid < pool_threads()) begin
					foreach (idle_threads[i])
						if (idle_threads[i] == qid) found = 1'b1;
					if (found) post(ST_IDLE, 0, qid, 0, 0, 1);
					foreach (run_list[i])
						if (!found && run_list[i].thr == qid) begin
							post(ST_BUSY, run_list[i].id, qid, run_list[i].remain, 0, 1);
							found = 1'b1;
						end
				end
				if (!found) post(ST_NOREPORT, 0, 0, 0, 0, 1);
			end
			MODE_RUN: begin
				if (rt > slice) begin
					best = 0;
					while (rt >= slice) begin
						v = run_slice(slice);
						if (v > best) best = v;
						rt -= slice;
					end
					v = best + run_slice(rt);
				end else begin
					v = run_slice(rt);
				end
				add_total(v);
				post(ST_TIME, 0, 0, 0, v, 1);
			end
			MODE_FINISH: begin
				while (run_list.size() > 0 || wait_list.size() > 0)
					add_total(run_slice(slice));
				post(ST_TIME, 0, 0, 0, elapsed_sum, 1);
			end
			default: post(ST_NOREPORT, 0, 0, 0, 0, 1);
		endcase
	endfunction

	// register writes, command beats and result beats
	always @(posedge clk or negedge arst_n) begin
		sched_result_t got, want;
		if (!arst_n) begin
			result_q.delete();
			wait_list.delete();
			run_list.delete();
			for (int i = 0; i < NTASK; i++) begin
				id_busy[i] = 1'b0;
				done_valid[i] = 1'b0;
				done_time[i] = 0;
			end
			elapsed_sum = 0;
			quantum = 100;
			pairs = 2;
			refill_pool();
			n_errors = 0;
			n_checked = 0;
			n_pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_QUANTUM) begin
					quantum = cfg_data;
				end else if (run_list.size() == 0) begin
					pairs = cfg_data[5:0];
					refill_pool();
				end
			end
			if (s_axis_tvalid && s_axis_tready) predict_command(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[3:0], m_axis_tdata[10:4], m_axis_tdata[16:11],
					m_axis_tdata[32:17], m_axis_tdata[56:33], m_axis_tlast};
				n_checked++;
				if (result_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 20)
						$display("%t unexpected result beat: actual %h", $time, got);
				end else begin
					want = result_q.pop_front();
					if (got !== want || m_axis_tdata[63:57] !== 7'd0) begin
						n_errors++;
						if (n_errors <= 20)
							$display("%t result mismatch: expected %h, actual %h",
								$time, want, got);
					end
				end
			end
			n_pending = result_q.size();
		end
	end

endmodule

>>> dv/priority_task_thread_scheduler_unit_tb.sv
// ----------------------------------------------------------------------------
// priority_task_thread_scheduler_unit_tb
// Drives directed and random scheduler commands with random stalls on both
// stream sides over several quantum and pool settings; the checker module
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module priority_task_thread_scheduler_unit_tb;
	import ptts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// mode, task_count, exec_time, priority_req, query_id, run_time, pad
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// status, task_id, thread_id, time_value, elapsed, pad
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;

	int n_errors, n_pending, n_checked;
	int send_idle_pct, recv_idle_pct;
	int hold_cycles;
	int n_sent;

	priority_task_thread_scheduler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	ptts_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.n_errors(n_errors), .n_pending(n_pending), .n_checked(n_checked)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result side: random stalls, or a long hold-off when requested
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// run limit
	initial begin
		#100ms;
		$display("priority_task_thread_scheduler_unit_tb: FAIL");
		$finish;
	end

	function automatic logic [55:0] pack_cmd(logic [2:0] mode, int unsigned cnt,
			int unsigned exec, int unsigned prio, int unsigned qid, int unsigned rt);
		return {1'b0, rt[15:0], qid[6:0], prio[7:0], exec[15:0], cnt[4:0], mode};
	endfunction

	// offer one command beat; valid stays high until the next command or a pause
	task automatic send(logic [55:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	// stop offering and wait until every expected result has come
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (n_pending != 0);
	endtask

	task automatic reg_write(logic idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random command; times scale with the quantum to keep slices few
	task automatic send_random(int unsigned q);
		logic [55:0] d;
		int unsigned r, lim_exec, lim_run, qq;
		qq = (q == 0) ? 1 : q;
		lim_exec = (qq * 4 > 65535) ? 65535 : qq * 4;
		lim_run = (qq * 8 > 65535) ? 65535 : qq * 8;
		d = {$urandom, $urandom};
		d[55] = 1'b0;
		r = $urandom_range(99);
		if (r < 35) begin
			d[2:0] = MODE_ADD;
			d[7:3] = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
			d[23:8] = $urandom_range(lim_exec);
			d[31:24] = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(3);
		end else if (r < 55) begin
			d[2:0] = MODE_QTASK;
			d[38:32] = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
		end else if (r < 70) begin
			d[2:0] = MODE_QTHREAD;
			d[38:32] = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(63);
		end else if (r < 90) begin
			d[2:0] = MODE_RUN;
			d[54:39] = $urandom_range(lim_run);
		end else if (r < 95) begin
			d[2:0] = MODE_FINISH;
		end else begin
			d[2:0] = $urandom_range(5, 7);
		end
		send(d);
	endtask

	initial begin
		int unsigned phase_q[6];
		int unsigned phase_p[6];
		int rnd_items;
		phase_q = '{65535, 1, 0, 500, 100, 3000};
		phase_p = '{32, 1, 63, 0, 2, 5};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_QUANTUM;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		hold_cycles = 0;
		n_sent = 0;
		rnd_items = 0;
		send_idle_pct = 21;
		recv_idle_pct = 74;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty add, saturated batch, zero execution time
		send(pack_cmd(MODE_ADD, 0, 5, 1, 0, 0));
		send(pack_cmd(MODE_ADD, 31, 65535, 255, 0, 0));
		send(pack_cmd(MODE_ADD, 1, 0, 0, 0, 0));
		// thread queries: idle, in pool, outside pool
		send(pack_cmd(MODE_QTHREAD, 1, 1, 1, 0, 0));
		send(pack_cmd(MODE_QTHREAD, 1, 1, 1, 3, 0));
		send(pack_cmd(MODE_QTHREAD, 1, 1, 1, 4, 0));
		send(pack_cmd(MODE_QTHREAD, 1, 1, 1, 127, 0));
		// zero-length run dispatches threads
		send(pack_cmd(MODE_RUN, 1, 1, 1, 0, 0));
		send(pack_cmd(MODE_QTASK, 1, 1, 1, 1, 0));
		send(pack_cmd(MODE_QTASK, 1, 1, 1, 17, 0));
		send(pack_cmd(MODE_QTASK, 1, 1, 1, 0, 0));
		send(pack_cmd(MODE_QTASK, 1, 1, 1, 127, 0));
		send(pack_cmd(MODE_QTHREAD, 1, 1, 1, 0, 0));
		// pool write while tasks run is dropped
		drain();
		reg_write(REG_THREADS, 16'd7);
		reg_write(REG_QUANTUM, 16'hFFFF);
		// fill every id, then reject
		send(pack_cmd(MODE_ADD, 16, 65535, 128, 0, 0));
		send(pack_cmd(MODE_ADD, 16, 40000, 127, 0, 0));
		send(pack_cmd(MODE_ADD, 16, 1, 255, 0, 0));
		send(pack_cmd(5, 0, 0, 0, 0, 0));
		send(pack_cmd(6, 0, 0, 0, 0, 0));
		send(pack_cmd(7, 31, 65535, 255, 127, 65535));
		send(pack_cmd(MODE_RUN, 0, 0, 0, 0, 65535));
		send(pack_cmd(MODE_FINISH, 0, 0, 0, 0, 0));
		send(pack_cmd(MODE_QTASK, 1, 1, 1, 1, 0));
		send(pack_cmd(MODE_QTASK, 1, 1, 1, 64, 0));

		// random phases over quantum and pool settings
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			reg_write(REG_QUANTUM, phase_q[ph][15:0]);
			reg_write(REG_THREADS, phase_p[ph][15:0]);
			for (int i = 0; i < 80; i++) begin
				if (rnd_items < 160) begin
					send_idle_pct = 21;
					recv_idle_pct = 74;
				end else if (rnd_items < 320) begin
					send_idle_pct = 74;
					recv_idle_pct = 21;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				// long result hold-off while random commands keep coming
				if (ph == 0 && i == 5) hold_cycles = 600;
				send_random(phase_q[ph]);
				rnd_items++;
			end
			send(pack_cmd(MODE_FINISH, 0, 0, 0, 0, 0));
		end

		drain();
		repeat (300) @(posedge clk);
		$display("summary: %0d commands sent, %0d result beats checked, %0d mismatches",
			n_sent, n_checked, n_errors);
		$display("summary: 6 quantum/pool settings, stalls on both sides, one long hold-off");
		if (n_errors == 0 && n_pending == 0) begin
			$display("priority_task_thread_scheduler_unit_tb: PASS");
		end else begin
			$display("priority_task_thread_scheduler_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/ptts_pkg.sv
design/ptts_dp.sv
design/ptts_ctrl.sv
design/priority_task_thread_scheduler_unit.sv
dv/ptts_checker.sv
dv/priority_task_thread_scheduler_unit_tb.sv
